### design/qou_pkg.sv
// ----------------------------------------------------------------------------
// qou_pkg
// Shared types, constants and tables for the orientation quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qou_pkg;

  localparam int QOU_CORDIC_STEPS_DEF = 24;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 128;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0,
    REQ_MUL  = 3'd1,
    REQ_ADD  = 3'd2,
    REQ_ROT  = 3'd3,
    REQ_NORM = 3'd4,
    REQ_AXIS = 3'd5
  } req_t;

  // multiplier operand sources
  typedef enum logic [4:0] {
    SRC_OW, SRC_OX, SRC_OY, SRC_OZ,
    SRC_QW, SRC_QX, SRC_QY, SRC_QZ,
    SRC_VX, SRC_VY, SRC_VZ, SRC_SC,
    SRC_SX, SRC_SY, SRC_SZ,
    SRC_UX, SRC_UY, SRC_UZ,
    SRC_CX, SRC_CY, SRC_SIN
  } src_t;

  localparam int SRC_N = 21;

  // multiply-accumulate jobs
  typedef enum logic [2:0] {
    JOB_QMUL, JOB_SVEC, JOB_QADD, JOB_QROT,
    JOB_SSQQ, JOB_SSQV, JOB_SSQC, JOB_AXIS
  } job_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
  } term_t;

  typedef struct packed {
    logic       cap;
    logic       mac_issue;
    logic       mac_first;
    job_t       job;
    logic [1:0] comp;
    logic [1:0] term;
    logic       fin;
    logic       zero_fill;
    logic       sq_start;
    logic       dv_start;
    logic       div_wr;
    logic       cord_init;
    logic       cord_step;
    logic [4:0] cord_idx;
    logic       w_from_cs;
    logic       commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic rd_done;
  } ctl_sts_t;

  function automatic src_t ori_src(input logic [1:0] k);
    src_t s;
    case (k)
      2'd0:    s = SRC_OW;
      2'd1:    s = SRC_OX;
      2'd2:    s = SRC_OY;
      default: s = SRC_OZ;
    endcase
    return s;
  endfunction

  function automatic src_t vec_src(input logic [1:0] k);
    src_t s;
    case (k)
      2'd0:    s = SRC_VX;
      2'd1:    s = SRC_VY;
      default: s = SRC_VZ;
    endcase
    return s;
  endfunction

  function automatic src_t unit_src(input logic [1:0] k);
    src_t s;
    case (k)
      2'd0:    s = SRC_UX;
      2'd1:    s = SRC_UY;
      default: s = SRC_UZ;
    endcase
    return s;
  endfunction

  function automatic term_t mk(input src_t a, input src_t b, input logic n);
    term_t t;
    t.a = a;
    t.b = b;
    t.neg = n;
    return t;
  endfunction

  function automatic term_t term_sel(input job_t job, input logic [1:0] comp,
                                     input logic [1:0] term);
    term_t t;
    t = mk(SRC_OW, SRC_OW, 1'b0);
    case (job)
      JOB_QMUL: begin
        case ({comp, term})
          4'h0: t = mk(SRC_OW, SRC_QW, 1'b0);
          4'h1: t = mk(SRC_OX, SRC_QX, 1'b1);
          4'h2: t = mk(SRC_OY, SRC_QY, 1'b1);
          4'h3: t = mk(SRC_OZ, SRC_QZ, 1'b1);
          4'h4: t = mk(SRC_OW, SRC_QX, 1'b0);
          4'h5: t = mk(SRC_OX, SRC_QW, 1'b0);
          4'h6: t = mk(SRC_OY, SRC_QZ, 1'b0);
          4'h7: t = mk(SRC_OZ, SRC_QY, 1'b1);
          4'h8: t = mk(SRC_OW, SRC_QY, 1'b0);
          4'h9: t = mk(SRC_OY, SRC_QW, 1'b0);
          4'ha: t = mk(SRC_OZ, SRC_QX, 1'b0);
          4'hb: t = mk(SRC_OX, SRC_QZ, 1'b1);
          4'hc: t = mk(SRC_OW, SRC_QZ, 1'b0);
          4'hd: t = mk(SRC_OZ, SRC_QW, 1'b0);
          4'he: t = mk(SRC_OX, SRC_QY, 1'b0);
          default: t = mk(SRC_OY, SRC_QX, 1'b1);
        endcase
      end
      JOB_SVEC: t = mk(vec_src(comp), SRC_SC, 1'b0);
      JOB_QADD: begin
        case ({comp, term})
          4'h0: t = mk(SRC_SX, SRC_OX, 1'b1);
          4'h1: t = mk(SRC_SY, SRC_OY, 1'b1);
          4'h2: t = mk(SRC_SZ, SRC_OZ, 1'b1);
          4'h4: t = mk(SRC_SX, SRC_OW, 1'b0);
          4'h5: t = mk(SRC_SY, SRC_OZ, 1'b0);
          4'h6: t = mk(SRC_SZ, SRC_OY, 1'b1);
          4'h8: t = mk(SRC_SY, SRC_OW, 1'b0);
          4'h9: t = mk(SRC_SZ, SRC_OX, 1'b0);
          4'ha: t = mk(SRC_SX, SRC_OZ, 1'b1);
          4'hc: t = mk(SRC_SZ, SRC_OW, 1'b0);
          4'hd: t = mk(SRC_SX, SRC_OY, 1'b0);
          default: t = mk(SRC_SY, SRC_OX, 1'b1);
        endcase
      end
      JOB_QROT: begin
        case ({comp, term})
          4'h0: t = mk(SRC_OX, SRC_VX, 1'b1);
          4'h1: t = mk(SRC_OY, SRC_VY, 1'b1);
          4'h2: t = mk(SRC_OZ, SRC_VZ, 1'b1);
          4'h4: t = mk(SRC_OW, SRC_VX, 1'b0);
          4'h5: t = mk(SRC_OY, SRC_VZ, 1'b0);
          4'h6: t = mk(SRC_OZ, SRC_VY, 1'b1);
          4'h8: t = mk(SRC_OW, SRC_VY, 1'b0);
          4'h9: t = mk(SRC_OZ, SRC_VX, 1'b0);
          4'ha: t = mk(SRC_OX, SRC_VZ, 1'b1);
          4'hc: t = mk(SRC_OW, SRC_VZ, 1'b0);
          4'hd: t = mk(SRC_OX, SRC_VY, 1'b0);
          default: t = mk(SRC_OY, SRC_VX, 1'b1);
        endcase
      end
      JOB_SSQQ: t = mk(ori_src(term), ori_src(term), 1'b0);
      JOB_SSQV: t = mk(vec_src(term), vec_src(term), 1'b0);
      JOB_SSQC: t = (term == 2'd0) ? mk(SRC_CX, SRC_CX, 1'b0) : mk(SRC_CY, SRC_CY, 1'b0);
      default:  t = mk(unit_src(2'(comp - 2'd1)), SRC_SIN, 1'b0);
    endcase
    return t;
  endfunction

  function automatic logic [2:0] job_nterms(input job_t job);
    logic [2:0] n;
    case (job)
      JOB_QMUL, JOB_SSQQ: n = 3'd4;
      JOB_QADD, JOB_QROT, JOB_SSQV: n = 3'd3;
      JOB_SSQC: n = 3'd2;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd843314857;
      5'd1:  a = 32'd497837829;
      5'd2:  a = 32'd263043837;
      5'd3:  a = 32'd133525159;
      5'd4:  a = 32'd67021687;
      5'd5:  a = 32'd33543516;
      5'd6:  a = 32'd16775851;
      5'd7:  a = 32'd8388437;
      5'd8:  a = 32'd4194283;
      5'd9:  a = 32'd2097149;
      5'd10: a = 32'd1048576;
      5'd11: a = 32'd524288;
      5'd12: a = 32'd262144;
      5'd13: a = 32'd131072;
      5'd14: a = 32'd65536;
      5'd15: a = 32'd32768;
      5'd16: a = 32'd16384;
      5'd17: a = 32'd8192;
      5'd18: a = 32'd4096;
      5'd19: a = 32'd2048;
      5'd20: a = 32'd1024;
      5'd21: a = 32'd512;
      5'd22: a = 32'd256;
      5'd23: a = 32'd128;
      5'd24: a = 32'd64;
      5'd25: a = 32'd32;
      5'd26: a = 32'd16;
      5'd27: a = 32'd8;
      5'd28: a = 32'd4;
      5'd29: a = 32'd2;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // saturate to 32 bits; top bit flags a clip
  function automatic logic [32:0] clip32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/qou_rootdiv.sv
// ----------------------------------------------------------------------------
// qou_rootdiv
// Bit-serial unit: 64-bit floor square root, then 63/32 divisions by it.
// ----------------------------------------------------------------------------
`default_nettype none

module qou_rootdiv
  import qou_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        sq_start,
  input  wire logic [63:0] sq_val,
  input  wire logic        dv_start,
  input  wire logic [62:0] dv_num,
  output logic             done,
  output logic [31:0]      root,
  output logic [31:0]      quo
);

  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] sq_t, sq_trial, dv_t, dv_d;

  always_comb begin
    sq_t     = {rem_r[32:0], sh_r[63:62]};
    sq_trial = {1'b0, res_r, 2'b01};
    dv_t     = {rem_r[33:0], sh_r[63]};
    dv_d     = {3'b0, root_r};
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    res_nxt  = res_r;
    root_nxt = root_r;
    if (sq_start) begin
      busy_nxt = 1'b1;
      div_nxt  = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      sh_nxt   = sq_val;
      res_nxt  = '0;
    end else if (dv_start) begin
      busy_nxt = 1'b1;
      div_nxt  = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {4'b0, dv_num[62:32]};
      sh_nxt   = {dv_num[31:0], 32'b0};
      res_nxt  = '0;
    end else if (busy_r) begin
      if (!div_r) begin
        sh_nxt = {sh_r[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          rem_nxt = sq_t - sq_trial;
          res_nxt = {res_r[30:0], 1'b1};
        end else begin
          rem_nxt = sq_t;
          res_nxt = {res_r[30:0], 1'b0};
        end
      end else begin
        sh_nxt = {sh_r[62:0], 1'b0};
        if (dv_t >= dv_d) begin
          rem_nxt = dv_t - dv_d;
          res_nxt = {res_r[30:0], 1'b1};
        end else begin
          rem_nxt = dv_t;
          res_nxt = {res_r[30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!div_r) begin
          root_nxt = res_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    res_r  <= res_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
  assign quo  = res_r;

endmodule

`default_nettype wire

### design/qou_dpath.sv
// ----------------------------------------------------------------------------
// qou_dpath
// Datapath: orientation state, shared multiplier and accumulator, CORDIC
// rotator, root/divide unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qou_dpath
  import qou_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_cmd_t              cmd,
  output ctl_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [2:0]            in_tuser,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                 out_tuser
);

  logic signed [31:0] ori_r [4];
  logic signed [31:0] nq_r [4];
  logic signed [31:0] q_r [4];
  logic signed [31:0] v_r [3];
  logic signed [31:0] sv_r [3];
  logic signed [31:0] u_r [3];
  logic signed [31:0] cs_r [2];
  logic signed [31:0] sc_r, ang_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [33:0] th_r;
  logic               flip_r;
  logic signed [63:0] prod_r;
  logic               pv_r, pfirst_r, pneg_r;
  logic signed [66:0] acc_r;
  logic               sat_r;
  logic signed [31:0] out_r [4];
  logic               out_sat_r;

  logic [SRC_N*32-1:0] src_bus;
  term_t               tsel;
  logic signed [31:0]  op_a, op_b;
  logic signed [66:0]  pext, fin_rnd, fin_sum;
  logic [32:0]         fin_clip, dw_clip;
  logic signed [32:0]  dsrc, dneg_v;
  logic                dneg;
  logic [31:0]         dmag;
  logic signed [33:0]  dw_o, dw_cs;
  logic [62:0]         dv_num;
  logic [63:0]         sq_val;
  logic                rd_done;
  logic [31:0]         root, quo;
  logic signed [33:0]  th0, at;
  logic signed [32:0]  dx, dy;

  // operand selection
  always_comb begin
    src_bus = '0;
    src_bus[32*int'(SRC_OW) +: 32] = ori_r[0];
    src_bus[32*int'(SRC_OX) +: 32] = ori_r[1];
    src_bus[32*int'(SRC_OY) +: 32] = ori_r[2];
    src_bus[32*int'(SRC_OZ) +: 32] = ori_r[3];
    src_bus[32*int'(SRC_QW) +: 32] = q_r[0];
    src_bus[32*int'(SRC_QX) +: 32] = q_r[1];
    src_bus[32*int'(SRC_QY) +: 32] = q_r[2];
    src_bus[32*int'(SRC_QZ) +: 32] = q_r[3];
    src_bus[32*int'(SRC_VX) +: 32] = v_r[0];
    src_bus[32*int'(SRC_VY) +: 32] = v_r[1];
    src_bus[32*int'(SRC_VZ) +: 32] = v_r[2];
    src_bus[32*int'(SRC_SC) +: 32] = sc_r;
    src_bus[32*int'(SRC_SX) +: 32] = sv_r[0];
    src_bus[32*int'(SRC_SY) +: 32] = sv_r[1];
    src_bus[32*int'(SRC_SZ) +: 32] = sv_r[2];
    src_bus[32*int'(SRC_UX) +: 32] = u_r[0];
    src_bus[32*int'(SRC_UY) +: 32] = u_r[1];
    src_bus[32*int'(SRC_UZ) +: 32] = u_r[2];
    src_bus[32*int'(SRC_CX) +: 32] = cx_r[31:0];
    src_bus[32*int'(SRC_CY) +: 32] = cy_r[31:0];
    src_bus[32*int'(SRC_SIN) +: 32] = cs_r[1];
    tsel = term_sel(cmd.job, cmd.comp, cmd.term);
    op_a = $signed(src_bus[{tsel.a, 5'b0} +: 32]);
    op_b = $signed(src_bus[{tsel.b, 5'b0} +: 32]);
  end

  // finish: round, add base for QADD, saturate
  always_comb begin
    pext = {{3{prod_r[63]}}, prod_r};
    case (cmd.job)
      JOB_SVEC: fin_rnd = (acc_r + 67'sd128) >>> 8;
      JOB_QADD: fin_rnd = (acc_r + 67'sd16777216) >>> 25;
      JOB_QROT: fin_rnd = (acc_r + 67'sd32768) >>> 16;
      default:  fin_rnd = (acc_r + 67'sd536870912) >>> 30;
    endcase
    if (cmd.job == JOB_QADD) begin
      fin_sum = fin_rnd + {{35{ori_r[cmd.comp][31]}}, ori_r[cmd.comp]};
    end else begin
      fin_sum = fin_rnd;
    end
    fin_clip = clip32(fin_sum);
  end

  // divide operands and results
  always_comb begin
    case (cmd.job)
      JOB_SSQQ: dsrc = {ori_r[cmd.comp][31], ori_r[cmd.comp]};
      JOB_SSQV: begin
        if (cmd.comp == 2'd3) begin
          dsrc = '0;
        end else begin
          dsrc = {v_r[cmd.comp][31], v_r[cmd.comp]};
        end
      end
      default:  dsrc = (cmd.comp == 2'd0) ? cx_r : cy_r;
    endcase
    dneg   = dsrc[32];
    dneg_v = -dsrc;
    dmag   = dneg ? dneg_v[31:0] : dsrc[31:0];
    dv_num = (63'(dmag) << 30) + 63'(root >> 1);
    sq_val = (acc_r[66:64] != 3'b000) ? '1 : acc_r[63:0];
    dw_o   = dneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    dw_cs  = flip_r ? -dw_o : dw_o;
    dw_clip = clip32({{33{dw_o[33]}}, dw_o});
  end

  // CORDIC
  always_comb begin
    th0 = {ang_r[31], ang_r, 1'b0};
    at  = $signed({2'b00, atan_q30(cmd.cord_idx)});
    dx  = cy_r >>> cmd.cord_idx;
    dy  = cx_r >>> cmd.cord_idx;
  end

  qou_rootdiv u_rootdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_start (cmd.sq_start),
    .sq_val   (sq_val),
    .dv_start (cmd.dv_start),
    .dv_num   (dv_num),
    .done     (rd_done),
    .root     (root),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ori_r[0] <= ONE_Q30;
      ori_r[1] <= '0;
      ori_r[2] <= '0;
      ori_r[3] <= '0;
      pv_r     <= 1'b0;
    end else begin
      pv_r <= cmd.mac_issue;
      if (cmd.commit) begin
        ori_r <= nq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= op_a * op_b;
    pfirst_r <= cmd.mac_first;
    pneg_r   <= tsel.neg;
    if (pv_r) begin
      acc_r <= (pfirst_r ? 67'sd0 : acc_r) + (pneg_r ? -pext : pext);
    end
    if (cmd.commit) begin
      out_r     <= nq_r;
      out_sat_r <= sat_r;
    end
    if (cmd.cap) begin
      q_r[0] <= in_tdata[31:0];
      q_r[1] <= in_tdata[63:32];
      q_r[2] <= in_tdata[95:64];
      q_r[3] <= in_tdata[127:96];
      v_r[0] <= in_tdata[159:128];
      v_r[1] <= in_tdata[191:160];
      v_r[2] <= in_tdata[223:192];
      sc_r   <= in_tdata[255:224];
      ang_r  <= in_tdata[287:256];
      sat_r  <= 1'b0;
      if (in_tuser == REQ_LOAD) begin
        nq_r[0] <= in_tdata[31:0];
        nq_r[1] <= in_tdata[63:32];
        nq_r[2] <= in_tdata[95:64];
        nq_r[3] <= in_tdata[127:96];
      end else begin
        nq_r <= ori_r;
      end
    end else if (cmd.fin) begin
      if (fin_clip[32]) begin
        sat_r <= 1'b1;
      end
      if (cmd.job == JOB_SVEC) begin
        sv_r[cmd.comp] <= fin_clip[31:0];
      end else begin
        nq_r[cmd.comp] <= fin_clip[31:0];
      end
    end else if (cmd.zero_fill) begin
      case (cmd.job)
        JOB_SSQQ: begin
          nq_r[0] <= ONE_Q30;
          nq_r[1] <= '0;
          nq_r[2] <= '0;
          nq_r[3] <= '0;
        end
        JOB_SSQV: begin
          u_r[0] <= '0;
          u_r[1] <= '0;
          u_r[2] <= '0;
        end
        default: begin
          cs_r[0] <= '0;
          cs_r[1] <= '0;
        end
      endcase
    end else if (cmd.div_wr) begin
      case (cmd.job)
        JOB_SSQQ: begin
          nq_r[cmd.comp] <= dw_clip[31:0];
          if (dw_clip[32]) begin
            sat_r <= 1'b1;
          end
        end
        JOB_SSQV: u_r[cmd.comp] <= dw_o[31:0];
        default:  cs_r[cmd.comp[0]] <= dw_cs[31:0];
      endcase
    end else if (cmd.w_from_cs) begin
      nq_r[0] <= cs_r[0];
    end
    if (cmd.cord_init) begin
      cx_r <= 33'sd1073741824;
      cy_r <= '0;
      if (th0 > HALF_PI_Q30) begin
        th_r   <= th0 - PI_Q30;
        flip_r <= 1'b1;
      end else if (th0 < -HALF_PI_Q30) begin
        th_r   <= th0 + PI_Q30;
        flip_r <= 1'b1;
      end else begin
        th_r   <= th0;
        flip_r <= 1'b0;
      end
    end else if (cmd.cord_step) begin
      if (!th_r[33]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        th_r <= th_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        th_r <= th_r + at;
      end
    end
  end

  assign sts.s_zero  = (acc_r == 67'sd0);
  assign sts.rd_done = rd_done;
  assign out_tdata   = {out_r[3], out_r[2], out_r[1], out_r[0]};
  assign out_tuser   = out_sat_r;

endmodule

`default_nettype wire

### design/qou_ctrl.sv
// ----------------------------------------------------------------------------
// qou_ctrl
// Controller: sequences multiply-accumulate jobs, root/divide passes and
// CORDIC rotations for each request, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module qou_ctrl
  import qou_pkg::*;
#(
  parameter int CORDIC_STEPS = QOU_CORDIC_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [2:0] in_tuser,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output ctl_cmd_t        cmd,
  input  wire ctl_sts_t   sts
);

  localparam int CIW = $clog2(CORDIC_STEPS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MAC   = 11'b000_0000_0010,
    S_FIN   = 11'b000_0000_0100,
    S_ROOT  = 11'b000_0000_1000,
    S_SQRT  = 11'b000_0001_0000,
    S_DVS   = 11'b000_0010_0000,
    S_DVW   = 11'b000_0100_0000,
    S_CINIT = 11'b000_1000_0000,
    S_CORD  = 11'b001_0000_0000,
    S_WCS   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  job_t           job_r, job_nxt;
  logic [1:0]     comp_r, comp_nxt;
  logic [2:0]     term_r, term_nxt;
  logic [CIW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     div_last;
  state_t         after_unit;

  always_comb begin
    // where to go once a unit-length pass completes
    case (job_r)
      JOB_SSQQ: begin
        div_last   = 2'd3;
        after_unit = S_DONE;
      end
      JOB_SSQV: begin
        div_last   = 2'd2;
        after_unit = S_CINIT;
      end
      default: begin
        div_last   = 2'd1;
        after_unit = S_WCS;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    comp_nxt      = comp_r;
    term_nxt      = term_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.job       = job_r;
    cmd.comp      = comp_r;
    cmd.term      = term_r[1:0];
    cmd.cord_idx  = 5'(cnt_r);
    in_tready     = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap  = 1'b1;
          comp_nxt = '0;
          term_nxt = '0;
          state_nxt = S_MAC;
          unique case (in_tuser)
            REQ_MUL:  job_nxt = JOB_QMUL;
            REQ_ADD:  job_nxt = JOB_SVEC;
            REQ_ROT:  job_nxt = JOB_QROT;
            REQ_NORM: job_nxt = JOB_SSQQ;
            REQ_AXIS: job_nxt = JOB_SSQV;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_MAC: begin
        if (term_r != job_nterms(job_r)) begin
          cmd.mac_issue = 1'b1;
          cmd.mac_first = (term_r == 3'd0);
          term_nxt = term_r + 3'd1;
        end else begin
          // drain the product register
          term_nxt = '0;
          if (job_r == JOB_SSQQ || job_r == JOB_SSQV || job_r == JOB_SSQC) begin
            state_nxt = S_ROOT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (job_r == JOB_SVEC && comp_r == 2'd2) begin
          job_nxt   = JOB_QADD;
          comp_nxt  = '0;
          state_nxt = S_MAC;
        end else if (comp_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_MAC;
        end
      end
      S_ROOT: begin
        if (sts.s_zero) begin
          cmd.zero_fill = 1'b1;
          state_nxt = after_unit;
        end else begin
          cmd.sq_start = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.rd_done) begin
          comp_nxt  = '0;
          state_nxt = S_DVS;
        end
      end
      S_DVS: begin
        cmd.dv_start = 1'b1;
        state_nxt = S_DVW;
      end
      S_DVW: begin
        if (sts.rd_done) begin
          cmd.div_wr = 1'b1;
          if (comp_r == div_last) begin
            state_nxt = after_unit;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_DVS;
          end
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (cnt_r == CIW'(CORDIC_STEPS - 1)) begin
          job_nxt   = JOB_SSQC;
          term_nxt  = '0;
          comp_nxt  = '0;
          state_nxt = S_MAC;
        end else begin
          cnt_nxt = cnt_r + CIW'(1);
        end
      end
      S_WCS: begin
        cmd.w_from_cs = 1'b1;
        job_nxt   = JOB_AXIS;
        comp_nxt  = 2'd1;
        term_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      job_r       <= JOB_QMUL;
      comp_r      <= '0;
      term_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      job_r       <= job_nxt;
      comp_r      <= comp_nxt;
      term_r      <= term_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### design/quaternion_orientation_unit_core.sv
// Build-from-axis runs 24 CORDIC steps by default (one step per cycle).
// Throughput: one request at a time; the serial root/divide unit and the
// single shared multiplier limit it.
// Reset: synchronous, active low; the quaternion returns to (1,0,0,0).
// ----------------------------------------------------------------------------
// quaternion_orientation_unit_core
// Orientation quaternion unit: load, multiply, integrate, rotate, normalise
// and build-from-axis on one Q2.30 quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_orientation_unit_core
  import qou_pkg::*;
#(
  parameter int CORDIC_STEPS = QOU_CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, scale, angle
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_w, out_x, out_y, out_z
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // saturated
  output logic [0:0]                 out_tuser
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  qou_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  qou_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire
